// ===== sv/scfu_pkg.sv =====
// Shared types, constants and helper functions of the sensor frame CRC unpacker.
package scfu_pkg;

	localparam int FRAME_LEN   = 86;
	localparam int CRC_LEN     = 84;
	localparam int ADDR_W      = 7;
	localparam int NUM_RECORDS = 41;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [6:0]  PM_SCALE = 7'd100;

	localparam logic [ADDR_W-1:0] POS_CRC_LO = ADDR_W'(CRC_LEN);
	localparam logic [ADDR_W-1:0] POS_LAST   = ADDR_W'(FRAME_LEN - 1);
	localparam logic [ADDR_W-1:0] POS_DONE   = ADDR_W'(FRAME_LEN);

	localparam logic [5:0] REC_TOF  = 6'd24;
	localparam logic [5:0] REC_ENV  = 6'd28;
	localparam logic [5:0] REC_PM   = 6'd32;
	localparam logic [5:0] REC_STAT = 6'd35;
	localparam logic [5:0] REC_LAST = 6'(NUM_RECORDS - 1);

	localparam logic [7:0] EXP_INF  = 8'hFF;
	localparam logic [7:0] EXP_BIAS_SHIFT = 8'd150;

	typedef enum logic [1:0] {
		KIND_WORD,
		KIND_BYTE,
		KIND_PM
	} rec_kind_t;

	typedef enum logic [2:0] {
		UP_IDLE,
		UP_ISSUE,
		UP_CAPT,
		UP_MUL,
		UP_EMIT,
		UP_REJ
	} unpack_state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic go;
		logic crc_ok;
	} frame_done_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic rec_kind_t rec_kind(input logic [5:0] k);
		rec_kind_t r;
		if (k < REC_TOF) begin
			r = KIND_WORD;
		end else if (k < REC_ENV) begin
			r = KIND_BYTE;
		end else if (k < REC_PM) begin
			r = KIND_WORD;
		end else if (k < REC_STAT) begin
			r = KIND_PM;
		end else begin
			r = KIND_WORD;
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] rec_base(input logic [5:0] k);
		logic [ADDR_W-1:0] k7;
		logic [ADDR_W-1:0] a;
		k7 = {1'b0, k};
		if (k < REC_TOF) begin
			a = {k, 1'b0};
		end else if (k < REC_ENV) begin
			a = 7'd48 + (k7 - {1'b0, REC_TOF});
		end else if (k < REC_PM) begin
			a = 7'd52 + ((k7 - {1'b0, REC_ENV}) << 1);
		end else if (k < REC_STAT) begin
			a = 7'd60 + ((k7 - {1'b0, REC_PM}) << 2);
		end else begin
			a = 7'd72 + ((k7 - {1'b0, REC_STAT}) << 1);
		end
		return a;
	endfunction

	function automatic logic [1:0] rec_last_byte(input rec_kind_t kind);
		logic [1:0] n;
		case (kind)
			KIND_BYTE: n = 2'd0;
			KIND_PM:   n = 2'd3;
			default:   n = 2'd1;
		endcase
		return n;
	endfunction

	// Shift and saturate step of the float to hundredths conversion; prod is
	// the full significand already multiplied by the scale.
	function automatic logic [15:0] pm_hundredths(input logic sgn, input logic [7:0] ex,
			input logic man_nz, input logic [30:0] prod);
		logic [7:0]  sh;
		logic [30:0] q;
		logic [15:0] r;
		sh = EXP_BIAS_SHIFT - ex;
		q  = prod >> sh[4:0];
		if (ex == EXP_INF) begin
			r = (man_nz || sgn) ? 16'h0000 : 16'hFFFF;
		end else if (sgn || ex == 8'h00) begin
			r = 16'h0000;
		end else if (ex >= EXP_BIAS_SHIFT) begin
			r = 16'hFFFF;
		end else if (sh >= 8'd32) begin
			r = 16'h0000;
		end else if (q > 31'h0000FFFF) begin
			r = 16'hFFFF;
		end else begin
			r = q[15:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/scfu_frame_ram.sv =====
// Frame byte memory: one write port and one registered read port.
module scfu_frame_ram (
	input  logic                          clk,
	input  scfu_pkg::ram_wr_t             wr,
	input  logic                          rd_en,
	input  logic [scfu_pkg::ADDR_W-1:0]   rd_addr,
	output logic [7:0]                    rd_data
);
	import scfu_pkg::*;

	logic [7:0] mem [FRAME_LEN];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/scfu_rx.sv =====
// Receive side: byte position, running CRC and the end-of-frame check.
module scfu_rx (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             rx_byte,
	input  logic                   frame_start,
	output scfu_pkg::ram_wr_t      wr,
	output scfu_pkg::frame_done_t  done
);
	import scfu_pkg::*;

	logic [ADDR_W-1:0] byte_cnt_q;
	logic [15:0]       crc_q;
	logic [7:0]        rx_lo_q;

	logic [ADDR_W-1:0] pos;
	logic [15:0]       crc_base;
	logic              take;

	assign pos      = frame_start ? '0 : byte_cnt_q;
	assign crc_base = frame_start ? CRC_INIT : crc_q;
	assign take     = accept && (pos < POS_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			crc_q      <= CRC_INIT;
		end else if (take) begin
			byte_cnt_q <= pos + 7'd1;
			crc_q      <= (pos < POS_CRC_LO) ? crc_feed(crc_base, rx_byte) : crc_base;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pos == POS_CRC_LO) begin
			rx_lo_q <= rx_byte;
		end
	end

	assign wr.en   = take;
	assign wr.addr = pos;
	assign wr.data = rx_byte;

	// The checksum word is little endian: byte 84 low, byte 85 high.
	assign done.go     = take && (pos == POS_LAST);
	assign done.crc_ok = ({rx_byte, rx_lo_q} == crc_base);

endmodule

// ===== sv/scfu_unpack.sv =====
// Record sequencer: reads the stored frame and issues the decoded records.
module scfu_unpack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scfu_pkg::frame_done_t         done,
	output logic                          busy,
	output logic                          rd_en,
	output logic [scfu_pkg::ADDR_W-1:0]   rd_addr,
	input  logic [7:0]                    rd_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [5:0]                    field_index,
	output logic [15:0]                   field_value,
	output logic                          crc_ok,
	output logic                          last_record
);
	import scfu_pkg::*;

	unpack_state_t state_q, state_d;
	logic [5:0]    rec_q;
	logic [1:0]    byte_q;
	logic [31:0]   data_q;
	logic [30:0]   prod_q;
	logic          out_valid_q;
	logic [5:0]    index_q;
	logic [15:0]   value_q;
	logic          ok_q;
	logic          last_q;

	rec_kind_t   kind;
	logic [1:0]  last_byte;
	logic        out_free;
	logic        load_out;
	logic        is_rej;
	logic [15:0] value_c;

	assign kind      = rec_kind(rec_q);
	assign last_byte = rec_last_byte(kind);
	assign out_free  = !out_valid_q || out_ready;
	assign is_rej    = (state_q == UP_REJ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= UP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = rec_base(rec_q) + {5'b0, byte_q};
		load_out = 1'b0;
		case (state_q)
			UP_IDLE: begin
				if (done.go) begin
					state_d = done.crc_ok ? UP_ISSUE : UP_REJ;
				end
			end
			UP_ISSUE: begin
				rd_en   = 1'b1;
				state_d = UP_CAPT;
			end
			UP_CAPT: begin
				if (byte_q == last_byte) begin
					state_d = (kind == KIND_PM) ? UP_MUL : UP_EMIT;
				end else begin
					state_d = UP_ISSUE;
				end
			end
			UP_MUL: begin
				state_d = UP_EMIT;
			end
			UP_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = (rec_q == REC_LAST) ? UP_IDLE : UP_ISSUE;
				end
			end
			UP_REJ: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = UP_IDLE;
				end
			end
			default: begin
				state_d = UP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q  <= '0;
			byte_q <= '0;
		end else begin
			if (state_q == UP_IDLE && done.go) begin
				rec_q  <= '0;
				byte_q <= '0;
			end else if (state_q == UP_CAPT) begin
				byte_q <= (byte_q == last_byte) ? 2'd0 : byte_q + 2'd1;
			end else if (state_q == UP_EMIT && load_out && rec_q != REC_LAST) begin
				rec_q <= rec_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == UP_CAPT) begin
			data_q[{byte_q, 3'b000} +: 8] <= rd_data;
		end
		if (state_q == UP_MUL) begin
			prod_q <= 31'({1'b1, data_q[22:0]}) * 31'(PM_SCALE);
		end
	end

	always_comb begin
		case (kind)
			KIND_BYTE: value_c = {8'h00, data_q[7:0]};
			KIND_PM:   value_c = pm_hundredths(data_q[31], data_q[30:23],
				(data_q[22:0] != 23'd0), prod_q);
			default:   value_c = data_q[15:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			index_q <= is_rej ? 6'd0 : rec_q;
			value_q <= is_rej ? 16'h0000 : value_c;
			ok_q    <= !is_rej;
			last_q  <= is_rej || (rec_q == REC_LAST);
		end
	end

	assign busy        = (state_q != UP_IDLE);
	assign out_valid   = out_valid_q;
	assign field_index = index_q;
	assign field_value = value_q;
	assign crc_ok      = ok_q;
	assign last_record = last_q;

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done.go |-> state_q == UP_IDLE)
		else $error("frame completed while records were still being issued");

	a_rec_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != UP_IDLE |-> rec_q <= REC_LAST)
		else $error("record counter ran past the last record");

	a_capt_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == UP_CAPT |-> $past(state_q) == UP_ISSUE)
		else $error("read data captured without a read issued");

endmodule

// ===== sv/sensor_frame_crc_unpacker_core.sv =====
// Top level of the sensor frame CRC unpacker.
//
// The block takes the 86 bytes of a particle-sensor data frame, one item per
// cycle while it is collecting, writes each byte into an 86-entry frame memory
// and runs a CRC-16/MODBUS over bytes 0 to 83 as the bytes go by. With the
// 86th byte the CRC is compared with the little-endian word in bytes 84 and 85.
// A mismatch gives one reject record (crc_ok low, last_record high). A match
// starts the record sequencer, which reads the frame back through the memory's
// single read port, issuing a read and then capturing its byte, and issues 41
// records: the histogram bins, the time-of-flight bytes, the environmental
// words, the three PM values in hundredths and the status words. While records
// are being produced in_ready is low; it rises again once the last record has
// been loaded into the output register, so the next frame may arrive while
// that record still waits to be taken. A word record takes two byte reads, a
// single byte record one read, and a PM value four reads and a multiply step
// before its record is issued. An accepted byte with frame_start high always
// begins a new frame and drops any partial one; bytes beyond the 86th without
// frame_start are accepted and ignored.
module sensor_frame_crc_unpacker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  field_index,
	output logic [15:0] field_value,
	output logic        crc_ok,
	output logic        last_record
);
	import scfu_pkg::*;

	ram_wr_t           wr;
	frame_done_t       done;
	logic              busy;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic              accept;

	// The receive side is held off only while the sequencer is busy, unpacking a
	// frame or issuing a reject record, since a next frame would overwrite the bytes still to be read.
	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	scfu_rx u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.wr          (wr),
		.done        (done)
	);

	scfu_frame_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The sequencer sees the end of the frame in the same cycle as the last
	// byte is taken, so in_ready falls before another item can slip in.
	scfu_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.done        (done),
		.busy        (busy),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.field_index (field_index),
		.field_value (field_value),
		.crc_ok      (crc_ok),
		.last_record (last_record)
	);

endmodule
